/* hw/rtl/tcw_pkg.sv */
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and cell helpers for the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

	// store geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;

	// field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int MEM_DEPTH = ROWS * (1 << COL_W);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_BAND_ONE_END = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_TWO_END = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ONE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_TWO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_THREE  = 3'd4;

	localparam logic [COL_W-1:0] RST_BAND_ONE_END = 7'd26;
	localparam logic [COL_W-1:0] RST_BAND_TWO_END = 7'd54;
	localparam logic [7:0]       RST_COLOR_ONE    = 8'h2f;
	localparam logic [7:0]       RST_COLOR_TWO    = 8'hf2;
	localparam logic [7:0]       RST_COLOR_THREE  = 8'h4f;

	// command codes
	localparam logic [1:0] CMD_WRITE     = 2'd0;
	localparam logic [1:0] CMD_BACKSPACE = 2'd1;
	localparam logic [1:0] CMD_READ      = 2'd2;
	localparam logic [1:0] CMD_CLEAR     = 2'd3;

	// special bytes
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	typedef enum logic [2:0] {
		OP_CHAR  = 3'd0,
		OP_CR    = 3'd1,
		OP_LF    = 3'd2,
		OP_BS    = 3'd3,
		OP_READ  = 3'd4,
		OP_CLEAR = 3'd5
	} op_kind_t;

	// one classified word between front and back
	typedef struct packed {
		op_kind_t          kind;
		logic [CHAR_W-1:0] ch;
		logic [COL_W-1:0]  rcol;
		logic [ROW_W-1:0]  rrow;
	} op_t;

	typedef struct packed {
		logic [COL_W-1:0] band_one_end;
		logic [COL_W-1:0] band_two_end;
		logic [7:0]       color_one;
		logic [7:0]       color_two;
		logic [7:0]       color_three;
	} cfg_t;

	// attribute byte for a column
	function automatic logic [7:0] band_color(logic [COL_W-1:0] col, cfg_t cfg);
		logic [7:0] c;
		if (col <= cfg.band_one_end)
			c = cfg.color_one;
		else if (col <= cfg.band_two_end)
			c = cfg.color_two;
		else
			c = cfg.color_three;
		return c;
	endfunction

	function automatic logic [CELL_W-1:0] make_cell(logic [CHAR_W-1:0] ch,
			logic [COL_W-1:0] col, cfg_t cfg);
		return {band_color(col, cfg), ch};
	endfunction

	// logical row to physical row of the circular store
	function automatic logic [ROW_W-1:0] phys_row(logic [ROW_W-1:0] row,
			logic [ROW_W-1:0] base);
		logic [ROW_W:0] sum;
		sum = {1'b0, row} + {1'b0, base};
		if (sum >= (ROW_W+1)'(ROWS))
			sum = sum - (ROW_W+1)'(ROWS);
		return sum[ROW_W-1:0];
	endfunction

endpackage

/* hw/rtl/tcw_front.sv */
// ---------------------------------------------------------------------------
// tcw_front
// Accepts input words, classifies them and buffers them in a two-entry queue.
// ---------------------------------------------------------------------------
module tcw_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       hold,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 command,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  logic [tcw_pkg::COL_W-1:0]  read_col,
	input  logic [tcw_pkg::ROW_W-1:0]  read_row,
	output logic                       op_valid,
	input  logic                       op_ready,
	output tcw_pkg::op_t               op
);
	import tcw_pkg::*;

	op_t        entry_q [0:1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	op_t        cls;
	logic       push;
	logic       pop;

	// classify the incoming word
	always_comb begin
		cls.ch   = char_code;
		cls.rcol = read_col;
		cls.rrow = read_row;
		case (command)
			CMD_WRITE: begin
				if (char_code == CHAR_CR)
					cls.kind = OP_CR;
				else if (char_code == CHAR_LF)
					cls.kind = OP_LF;
				else
					cls.kind = OP_CHAR;
			end
			CMD_BACKSPACE: cls.kind = OP_BS;
			CMD_READ:      cls.kind = OP_READ;
			default:       cls.kind = OP_CLEAR;
		endcase
	end

	assign in_ready = (count_q != 2'd2) && !hold;
	assign push     = in_valid && in_ready;
	assign op_valid = (count_q != 2'd0);
	assign pop      = op_valid && op_ready;
	assign op       = entry_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= cls;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/tcw_back.sv */
// ---------------------------------------------------------------------------
// tcw_back
// Carries out queued words on the screen store and registers the results.
// ---------------------------------------------------------------------------
module tcw_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tcw_pkg::cfg_t              cfg,
	output logic                       init_busy,
	input  logic                       op_valid,
	output logic                       op_ready,
	input  tcw_pkg::op_t               op,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       wrote_cell,
	output logic [tcw_pkg::COL_W-1:0]  cell_col,
	output logic [tcw_pkg::ROW_W-1:0]  cell_row,
	output logic [tcw_pkg::CELL_W-1:0] cell_value,
	output logic                       scrolled,
	output logic [tcw_pkg::COL_W-1:0]  cursor_col,
	output logic [tcw_pkg::ROW_W-1:0]  cursor_row,
	output logic [tcw_pkg::CELL_W-1:0] read_value
);
	import tcw_pkg::*;

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_EXEC   = 7'b0000100,
		ST_RDATA  = 7'b0001000,
		ST_SCROLL = 7'b0010000,
		ST_CLEAR  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} back_state_t;

	back_state_t       state_q;
	op_t               op_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [ROW_W-1:0]  base_q;
	logic [COL_W-1:0]  sw_col_q;
	logic [ROW_W-1:0]  sw_row_q;
	logic              res_wrote_q;
	logic [COL_W-1:0]  res_col_q;
	logic [ROW_W-1:0]  res_row_q;
	logic [CELL_W-1:0] res_val_q;
	logic              res_scr_q;
	logic [CELL_W-1:0] res_read_q;
	logic [CELL_W-1:0] rd_data_q;
	logic [CELL_W-1:0] mem [0:MEM_DEPTH-1];

	logic              out_valid_q;
	logic              out_wrote_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [CELL_W-1:0] out_val_q;
	logic              out_scr_q;
	logic [COL_W-1:0]  out_cur_col_q;
	logic [ROW_W-1:0]  out_cur_row_q;
	logic [CELL_W-1:0] out_read_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              rd_en;
	logic              rd_in_range;
	logic [ADDR_W-1:0] rd_addr;
	logic [ROW_W-1:0]  cur_prow;
	logic [COL_W-1:0]  bs_col;
	logic              sw_last_col;
	logic              load_out;

	assign init_busy   = (state_q == ST_INIT);
	assign op_ready    = (state_q == ST_IDLE);
	assign cur_prow    = phys_row(cur_row_q, base_q);
	assign bs_col      = cur_col_q - COL_W'(1);
	assign sw_last_col = (sw_col_q == LAST_COL);
	assign load_out    = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign rd_in_range = ({1'b0, op_q.rcol} < (COL_W+1)'(COLUMNS))
		&& ({1'b0, op_q.rrow} < (ROW_W+1)'(ROWS));
	assign rd_en       = (state_q == ST_EXEC) && (op_q.kind == OP_READ) && rd_in_range;
	assign rd_addr     = {phys_row(op_q.rrow, base_q), op_q.rcol};

	// store write port select
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {cur_prow, cur_col_q};
		mem_wdata = make_cell(op_q.ch, cur_col_q, cfg);
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = {sw_row_q, sw_col_q};
				mem_wdata = '0;
			end
			ST_EXEC: begin
				if (op_q.kind == OP_CHAR) begin
					mem_we = 1'b1;
				end else if (op_q.kind == OP_BS) begin
					mem_we    = (cur_col_q != '0);
					mem_waddr = {cur_prow, bs_col};
					mem_wdata = make_cell(BLANK_CHAR, bs_col, cfg);
				end
			end
			ST_SCROLL: begin
				// old top row becomes the new bottom row
				mem_we    = 1'b1;
				mem_waddr = {base_q, sw_col_q};
				mem_wdata = make_cell(BLANK_CHAR, sw_col_q, cfg);
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = {sw_row_q, sw_col_q};
				mem_wdata = make_cell(BLANK_CHAR, sw_col_q, cfg);
			end
			default: mem_we = 1'b0;
		endcase
	end

	// screen store
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			op_q        <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			base_q      <= '0;
			sw_col_q    <= '0;
			sw_row_q    <= '0;
			res_wrote_q <= 1'b0;
			res_col_q   <= '0;
			res_row_q   <= '0;
			res_val_q   <= '0;
			res_scr_q   <= 1'b0;
			res_read_q  <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					// zero every cell after reset
					if (sw_last_col) begin
						sw_col_q <= '0;
						if (sw_row_q == LAST_ROW) begin
							sw_row_q <= '0;
							state_q  <= ST_IDLE;
						end else begin
							sw_row_q <= sw_row_q + ROW_W'(1);
						end
					end else begin
						sw_col_q <= sw_col_q + COL_W'(1);
					end
				end
				ST_IDLE: begin
					if (op_valid) begin
						op_q        <= op;
						res_wrote_q <= 1'b0;
						res_col_q   <= '0;
						res_row_q   <= '0;
						res_val_q   <= '0;
						res_scr_q   <= 1'b0;
						res_read_q  <= '0;
						state_q     <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					case (op_q.kind)
						OP_CHAR: begin
							res_wrote_q <= 1'b1;
							res_col_q   <= cur_col_q;
							res_row_q   <= cur_row_q;
							res_val_q   <= mem_wdata;
							if (cur_col_q == LAST_COL) begin
								cur_col_q <= '0;
								if (cur_row_q == LAST_ROW) begin
									res_scr_q <= 1'b1;
									sw_col_q  <= '0;
									state_q   <= ST_SCROLL;
								end else begin
									cur_row_q <= cur_row_q + ROW_W'(1);
								end
							end else begin
								cur_col_q <= cur_col_q + COL_W'(1);
							end
						end
						OP_CR: cur_col_q <= '0;
						OP_LF: begin
							if (cur_row_q == LAST_ROW) begin
								res_scr_q <= 1'b1;
								sw_col_q  <= '0;
								state_q   <= ST_SCROLL;
							end else begin
								cur_row_q <= cur_row_q + ROW_W'(1);
							end
						end
						OP_BS: begin
							if (cur_col_q != '0) begin
								res_wrote_q <= 1'b1;
								res_col_q   <= bs_col;
								res_row_q   <= cur_row_q;
								res_val_q   <= mem_wdata;
								cur_col_q   <= bs_col;
							end
						end
						OP_READ: begin
							if (rd_in_range)
								state_q <= ST_RDATA;
						end
						OP_CLEAR: begin
							sw_col_q <= '0;
							sw_row_q <= '0;
							state_q  <= ST_CLEAR;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_RDATA: begin
					res_read_q <= rd_data_q;
					state_q    <= ST_DONE;
				end
				ST_SCROLL: begin
					// blank the recycled row, then rotate the base
					if (sw_last_col) begin
						sw_col_q <= '0;
						base_q   <= (base_q == LAST_ROW) ? '0 : base_q + ROW_W'(1);
						state_q  <= ST_DONE;
					end else begin
						sw_col_q <= sw_col_q + COL_W'(1);
					end
				end
				ST_CLEAR: begin
					if (sw_last_col) begin
						sw_col_q <= '0;
						if (sw_row_q == LAST_ROW) begin
							sw_row_q <= '0;
							state_q  <= ST_DONE;
						end else begin
							sw_row_q <= sw_row_q + ROW_W'(1);
						end
					end else begin
						sw_col_q <= sw_col_q + COL_W'(1);
					end
				end
				ST_DONE: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			out_wrote_q   <= 1'b0;
			out_col_q     <= '0;
			out_row_q     <= '0;
			out_val_q     <= '0;
			out_scr_q     <= 1'b0;
			out_cur_col_q <= '0;
			out_cur_row_q <= '0;
			out_read_q    <= '0;
		end else if (load_out) begin
			out_valid_q   <= 1'b1;
			out_wrote_q   <= res_wrote_q;
			out_col_q     <= res_col_q;
			out_row_q     <= res_row_q;
			out_val_q     <= res_val_q;
			out_scr_q     <= res_scr_q;
			out_cur_col_q <= cur_col_q;
			out_cur_row_q <= cur_row_q;
			out_read_q    <= res_read_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign wrote_cell = out_wrote_q;
	assign cell_col   = out_col_q;
	assign cell_row   = out_row_q;
	assign cell_value = out_val_q;
	assign scrolled   = out_scr_q;
	assign cursor_col = out_cur_col_q;
	assign cursor_row = out_cur_row_q;
	assign read_value = out_read_q;

endmodule

/* hw/rtl/text_console_writer.sv */
// ---------------------------------------------------------------------------
// text_console_writer
// Text console engine over a 25 x 80 cell store with column-band colours.
// ---------------------------------------------------------------------------
// After reset the store is zeroed by a clearing pass over the ROWS*COLUMNS
// (2000) cells, during which in_ready stays low; configuration writes are
// taken at any time. A front end accepts and classifies words into a
// two-entry queue; the back end works one word at a time against a
// single-port-write store. A word goes from the queue through ST_EXEC to
// ST_DONE and the output register; an in-range cell read adds ST_RDATA
// (registered store read). A scroll blanks the COLUMNS (80) cells of the
// recycled bottom row, one cell per cycle through the store write port;
// rows are addressed through a rotating base, so no row is copied. A clear
// blanks all ROWS*COLUMNS (2000) cells. The next word is taken while a
// finished result waits on the output.
// ---------------------------------------------------------------------------
module text_console_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  char_code,
	input  logic [6:0]  read_col,
	input  logic [4:0]  read_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        wrote_cell,
	output logic [6:0]  cell_col,
	output logic [4:0]  cell_row,
	output logic [15:0] cell_value,
	output logic        scrolled,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic [15:0] read_value
);
	import tcw_pkg::*;

	cfg_t cfg_q;
	op_t  op;
	logic op_valid;
	logic op_ready;
	logic init_busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_one_end <= RST_BAND_ONE_END;
			cfg_q.band_two_end <= RST_BAND_TWO_END;
			cfg_q.color_one    <= RST_COLOR_ONE;
			cfg_q.color_two    <= RST_COLOR_TWO;
			cfg_q.color_three  <= RST_COLOR_THREE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BAND_ONE_END: cfg_q.band_one_end <= cfg_data[COL_W-1:0];
				CFG_BAND_TWO_END: cfg_q.band_two_end <= cfg_data[COL_W-1:0];
				CFG_COLOR_ONE:    cfg_q.color_one    <= cfg_data;
				CFG_COLOR_TWO:    cfg_q.color_two    <= cfg_data;
				CFG_COLOR_THREE:  cfg_q.color_three  <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (init_busy),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.char_code (char_code),
		.read_col  (read_col),
		.read_row  (read_row),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op)
	);

	tcw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.init_busy  (init_busy),
		.op_valid   (op_valid),
		.op_ready   (op_ready),
		.op         (op),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.wrote_cell (wrote_cell),
		.cell_col   (cell_col),
		.cell_row   (cell_row),
		.cell_value (cell_value),
		.scrolled   (scrolled),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.read_value (read_value)
	);

	// no word taken while the store is being zeroed
	a_init_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !in_ready)
		else $error("word accepted during clearing pass");

	// reported cursor stays inside the store
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cursor_row <= LAST_ROW) && (cursor_col <= LAST_COL))
		else $error("cursor outside the store");

	// no written cell means an empty cell value and column
	a_no_write_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !wrote_cell) |-> (cell_value == '0) && (cell_col == '0))
		else $error("cell fields set without a write");

	// a read result and a cell write never come from the same word
	a_read_or_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && wrote_cell) |-> (read_value == '0))
		else $error("read value on a writing word");

endmodule
